// ===== sv/slaq_pkg.sv =====
// Shared constants for the serial line assembler queue.
package slaq_pkg;

  localparam int LINE_BYTES_DEF  = 64;
  localparam int QUEUE_DEPTH_DEF = 8;

  localparam logic [7:0] CR_BYTE = 8'h0D;
  localparam logic [7:0] LF_BYTE = 8'h0A;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_POP  = 1'b1;

endpackage

// ===== sv/serial_line_assembler_queue_core.sv =====
// Top level: assembles received bytes into lines and queues them for popping.
//
//  channel | direction | ports
//  --------+-----------+----------------------------------------------------------
//  in      | input     | in_valid, in_ready, in_mode, in_rx_byte
//  out     | output    | out_valid, out_ready, out_line_char, out_last_char,
//          |           | out_line_empty, out_lines_waiting
//
// A received byte is written straight into the line slot at the queue tail, so bytes
// stream at one per cycle while no pop is in progress. A pop is accepted, the line
// length memory is read, then characters come out of the line memory at one per cycle
// while out_ready is high; a pop of an empty queue or line gives one result.
// A stalled result holds in the memory read register. Input is taken only while no
// pop is in progress. Reset clears the fill index, queue pointers and control; the
// memories are not cleared.
module serial_line_assembler_queue_core #(
  parameter int LINE_BYTES  = slaq_pkg::LINE_BYTES_DEF,
  parameter int QUEUE_DEPTH = slaq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_mode,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_line_char,
  output logic       out_last_char,
  output logic       out_line_empty,
  output logic [3:0] out_lines_waiting
);

  localparam int SLOT_BYTES = LINE_BYTES - 1;
  localparam int SLOT_CNT   = QUEUE_DEPTH + 1;
  localparam int FILL_W     = $clog2(LINE_BYTES);
  localparam int OFF_W      = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  localparam int SLT_W      = $clog2(SLOT_CNT);
  localparam int CNT_W      = $clog2(SLOT_CNT);
  localparam int LMEM_DEPTH = SLOT_CNT * (2 ** OFF_W);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LEN    = 3'b010,
    S_STREAM = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              zero_seen_r, zero_seen_nxt;
  logic [FILL_W-1:0] eff_len_r, eff_len_nxt;
  logic [SLT_W-1:0]  head_r, head_nxt;
  logic [SLT_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SLT_W-1:0]  pop_slot_r, pop_slot_nxt;
  logic [FILL_W-1:0] idx_r, idx_nxt;
  logic [FILL_W-1:0] len_r, len_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              last_r, last_nxt;
  logic              empty_r, empty_nxt;
  logic [CNT_W-1:0]  waiting_r, waiting_nxt;

  logic              in_fire, out_fire, byte_fire, pop_fire;
  logic              is_cr, is_lf, room, enq;
  logic [FILL_W-1:0] line_len;

  logic                    lw_en;
  logic [SLT_W+OFF_W-1:0]  lw_addr;
  logic                    lr_en;
  logic [SLT_W+OFF_W-1:0]  lr_addr;
  logic [7:0]              ch_q;
  logic                    nr_en;
  logic [FILL_W-1:0]       len_q;
  logic [CNT_W+3:0]        waiting_ext;

  function automatic logic [SLT_W-1:0] slot_inc(input logic [SLT_W-1:0] s);
    logic [SLT_W-1:0] r;
    r = (s == SLT_W'(SLOT_CNT - 1)) ? '0 : s + SLT_W'(1);
    return r;
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign byte_fire = in_fire && (in_mode == slaq_pkg::MODE_BYTE);
  assign pop_fire  = in_fire && (in_mode == slaq_pkg::MODE_POP);

  assign is_cr    = (in_rx_byte == slaq_pkg::CR_BYTE);
  assign is_lf    = (in_rx_byte == slaq_pkg::LF_BYTE);
  assign room     = (fill_r < FILL_W'(SLOT_BYTES));
  // A line ends at its first zero byte when popped, so store that length.
  assign line_len = zero_seen_r ? eff_len_r : fill_r;
  assign enq      = byte_fire && is_lf && (fill_r != '0) &&
                    (count_r < CNT_W'(QUEUE_DEPTH));

  assign lw_en   = byte_fire && !is_cr && !is_lf && room;
  assign lw_addr = {tail_r, fill_r[OFF_W-1:0]};
  assign nr_en   = pop_fire && (count_r != '0);

  always_comb begin
    lr_en   = 1'b0;
    lr_addr = {pop_slot_r, idx_r[OFF_W-1:0]};
    if (state_r == S_LEN && len_q != '0) begin
      lr_en   = 1'b1;
      lr_addr = {pop_slot_r, {OFF_W{1'b0}}};
    end else if (state_r == S_STREAM && out_fire && !last_r) begin
      lr_en = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    zero_seen_nxt = zero_seen_r;
    eff_len_nxt   = eff_len_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    pop_slot_nxt  = pop_slot_r;
    idx_nxt       = idx_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r;
    last_nxt      = last_r;
    empty_nxt     = empty_r;
    waiting_nxt   = waiting_r;

    unique case (state_r)
      S_IDLE: begin
        if (byte_fire) begin
          if (is_cr) begin
            // ignore
          end else if (is_lf) begin
            fill_nxt      = '0;
            zero_seen_nxt = 1'b0;
            if (enq) begin
              tail_nxt  = slot_inc(tail_r);
              count_nxt = count_r + CNT_W'(1);
            end
          end else if (room) begin
            fill_nxt = fill_r + FILL_W'(1);
            if (in_rx_byte == 8'd0 && !zero_seen_r) begin
              zero_seen_nxt = 1'b1;
              eff_len_nxt   = fill_r;
            end
          end else begin
            // overlong line: discard it and drop this byte
            fill_nxt      = '0;
            zero_seen_nxt = 1'b0;
          end
        end else if (pop_fire) begin
          if (count_r == '0) begin
            out_valid_nxt = 1'b1;
            last_nxt      = 1'b1;
            empty_nxt     = 1'b1;
            waiting_nxt   = '0;
            state_nxt     = S_STREAM;
          end else begin
            pop_slot_nxt = head_r;
            head_nxt     = slot_inc(head_r);
            count_nxt    = count_r - CNT_W'(1);
            state_nxt    = S_LEN;
          end
        end
      end
      S_LEN: begin
        waiting_nxt   = count_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_STREAM;
        if (len_q == '0) begin
          last_nxt  = 1'b1;
          empty_nxt = 1'b1;
        end else begin
          empty_nxt = 1'b0;
          last_nxt  = (len_q == FILL_W'(1));
          idx_nxt   = FILL_W'(1);
          len_nxt   = len_q;
        end
      end
      S_STREAM: begin
        if (out_fire) begin
          if (last_r) begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            // advance to the next character
            idx_nxt  = idx_r + FILL_W'(1);
            last_nxt = ((idx_r + FILL_W'(1)) == len_r);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      zero_seen_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      zero_seen_r <= zero_seen_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    eff_len_r  <= eff_len_nxt;
    pop_slot_r <= pop_slot_nxt;
    idx_r      <= idx_nxt;
    len_r      <= len_nxt;
    last_r     <= last_nxt;
    empty_r    <= empty_nxt;
    waiting_r  <= waiting_nxt;
  end

  slaq_ram #(
    .DEPTH  (LMEM_DEPTH),
    .DATA_W (8),
    .ADDR_W (SLT_W + OFF_W)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (lw_en),
    .wr_addr (lw_addr),
    .wr_data (in_rx_byte),
    .rd_en   (lr_en),
    .rd_addr (lr_addr),
    .rd_data (ch_q)
  );

  slaq_ram #(
    .DEPTH  (SLOT_CNT),
    .DATA_W (FILL_W),
    .ADDR_W (SLT_W)
  ) u_len_store (
    .clk     (clk),
    .wr_en   (enq),
    .wr_addr (tail_r),
    .wr_data (line_len),
    .rd_en   (nr_en),
    .rd_addr (head_r),
    .rd_data (len_q)
  );

  assign waiting_ext       = {4'd0, waiting_r};
  assign out_valid         = out_valid_r;
  assign out_line_char     = empty_r ? 8'd0 : ch_q;
  assign out_last_char     = last_r;
  assign out_line_empty    = empty_r;
  assign out_lines_waiting = waiting_ext[3:0];

endmodule

// ===== sv/slaq_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
module slaq_ram #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
